@@ design/page_replacement_selector_defines.svh @@
// assertion macros for the page replacement selector
// no dependencies; included by the top level only
`ifndef PAGE_REPLACEMENT_SELECTOR_DEFINES_SVH
`define PAGE_REPLACEMENT_SELECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PRS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/prs_pkg.sv @@
// shared types and codes for the page replacement selector
// no dependencies
package prs_pkg;
	localparam int RESIDENT_PAGES_DEF = 16;
	localparam int PAGE_BITS_DEF = 20;
	localparam int COUNT_BITS_DEF = 16;
	localparam int PAGE_OUT_BITS = 20;
	localparam int CNT_OUT_BITS = 5;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0, CMD_ACCESS = 2'd1, CMD_EVICT = 2'd2, CMD_REMOVE = 2'd3
	} cmd_t;
	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_NOT_FOUND = 2'd2, ST_RESIDENT = 2'd3
	} status_t;
	typedef enum logic [1:0] {
		POL_NEWEST = 2'd0, POL_SECOND = 2'd1, POL_LEAST = 2'd2, POL_ALT = 2'd3
	} policy_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the command
		logic scan_clr;  // reset scan pointer and search results
		logic scan_step; // examine one entry, advance pointer
		logic rotate;    // move head to tail, clear its bit
		logic sel_tail;  // victim = tail
		logic sel_head;  // victim = head
		logic sel_min;   // victim = least accessed
		logic sel_found; // target = matched entry
		logic shift_step;// move entry above target down one
		logic shift_done;// decrement count after removal
		logic append;    // write new page at tail
		logic touch;     // set referenced bit and bump count
		logic capture_victim;
	} prs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic found;
		logic empty;
		logic full;
		logic head_ref;
		logic shift_last;
	} prs_stat_t;
endpackage

@@ design/prs_datapath.sv @@
// entry list, search and shift datapath of the page replacement selector
// depends on prs_pkg
module prs_datapath import prs_pkg::*; #(
	parameter int RESIDENT_PAGES = RESIDENT_PAGES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  prs_cmd_t ctl,
	output prs_stat_t stat,
	input  logic [PAGE_BITS-1:0] page_in,
	input  logic mark_in,
	output logic [PAGE_BITS-1:0] victim_q,
	output logic [$clog2(RESIDENT_PAGES+1)-1:0] live_q
);
	localparam int IW = $clog2(RESIDENT_PAGES);
	localparam int LW = $clog2(RESIDENT_PAGES+1);

	logic [PAGE_BITS-1:0] page_q [RESIDENT_PAGES];
	logic ref_q [RESIDENT_PAGES];
	logic [COUNT_BITS-1:0] cnt_q [RESIDENT_PAGES];
	logic [PAGE_BITS-1:0] pg_q;
	logic mark_q;
	logic [IW-1:0] ptr_q, hit_q, min_q, tgt_q;
	logic found_q;
	logic [COUNT_BITS-1:0] minc_q;
	logic [IW-1:0] tail;

	assign tail = IW'(live_q - LW'(1));
	assign stat.scan_last = (LW'(ptr_q) + LW'(1)) >= live_q;
	assign stat.found = found_q;
	assign stat.empty = live_q == '0;
	assign stat.full = live_q == LW'(RESIDENT_PAGES);
	assign stat.head_ref = ref_q[0];
	assign stat.shift_last = (LW'(tgt_q) + LW'(1)) >= live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			found_q <= 1'b0;
			ptr_q <= '0;
		end else begin
			if (ctl.load) begin
				pg_q <= page_in;
				mark_q <= mark_in;
			end
			if (ctl.scan_clr) begin
				ptr_q <= '0;
				found_q <= 1'b0;
				min_q <= '0;
				minc_q <= cnt_q[0];
			end
			if (ctl.scan_step) begin
				ptr_q <= ptr_q + IW'(1);
				if (!found_q && page_q[ptr_q] == pg_q) begin
					found_q <= 1'b1;
					hit_q <= ptr_q;
				end
				if (cnt_q[ptr_q] < minc_q) begin
					minc_q <= cnt_q[ptr_q];
					min_q <= ptr_q;
				end
			end
			if (ctl.rotate) begin
				for (int i = 0; i < RESIDENT_PAGES - 1; i++) begin
					if (LW'(i) + LW'(1) < live_q) begin
						page_q[i] <= page_q[i+1];
						ref_q[i] <= ref_q[i+1];
						cnt_q[i] <= cnt_q[i+1];
					end
				end
				page_q[tail] <= page_q[0];
				ref_q[tail] <= 1'b0;
				cnt_q[tail] <= cnt_q[0];
			end
			if (ctl.sel_tail) tgt_q <= tail;
			if (ctl.sel_head) tgt_q <= '0;
			if (ctl.sel_min) tgt_q <= min_q;
			if (ctl.sel_found) tgt_q <= hit_q;
			if (ctl.capture_victim) victim_q <= page_q[tgt_q];
			if (ctl.shift_step) begin
				page_q[tgt_q] <= page_q[tgt_q + IW'(1)];
				ref_q[tgt_q] <= ref_q[tgt_q + IW'(1)];
				cnt_q[tgt_q] <= cnt_q[tgt_q + IW'(1)];
				tgt_q <= tgt_q + IW'(1);
			end
			if (ctl.shift_done) live_q <= live_q - LW'(1);
			if (ctl.append) begin
				page_q[IW'(live_q)] <= pg_q;
				ref_q[IW'(live_q)] <= mark_q;
				cnt_q[IW'(live_q)] <= '0;
				live_q <= live_q + LW'(1);
			end
			if (ctl.touch) begin
				ref_q[hit_q] <= 1'b1;
				if (cnt_q[hit_q] != '1) cnt_q[hit_q] <= cnt_q[hit_q] + COUNT_BITS'(1);
			end
		end
	end
endmodule

@@ design/prs_ctrl.sv @@
// command sequencer of the page replacement selector
// depends on prs_pkg
module prs_ctrl import prs_pkg::*; #(
	parameter int RESIDENT_PAGES = RESIDENT_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic [1:0] cmd_in,
	input  logic [1:0] policy,
	input  prs_stat_t stat,
	output prs_cmd_t ctl,
	output logic busy_q,
	output logic done_q,
	output logic [1:0] status_q,
	output logic vvalid_q
);
	localparam int RW = $clog2(RESIDENT_PAGES+1);
	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_CHOOSE, S_SC, S_MINSCAN, S_PICK, S_CAP,
		S_SHIFT, S_AFTER
	} state_t;
	state_t state_q;
	cmd_t cmd_q;
	logic [RW-1:0] rot_q;

	always_comb begin
		ctl = '0;
		ctl.load = in_fire;
		unique case (state_q)
			S_IDLE: ctl.scan_clr = in_fire;
			S_SCAN: ctl.scan_step = 1'b1;
			S_CHOOSE: begin
				ctl.scan_clr = 1'b1;
				if (policy == POL_NEWEST) ctl.sel_tail = 1'b1;
			end
			S_SC: begin
				if (stat.head_ref && rot_q != '0) ctl.rotate = 1'b1;
				else ctl.sel_head = 1'b1;
			end
			S_MINSCAN: ctl.scan_step = 1'b1;
			S_PICK: ctl.sel_min = 1'b1;
			S_DECIDE: ctl.sel_found = stat.found;
			S_CAP: ctl.capture_victim = 1'b1;
			S_SHIFT: begin
				if (stat.shift_last) ctl.shift_done = 1'b1;
				else ctl.shift_step = 1'b1;
			end
			S_AFTER: begin
				ctl.append = cmd_q == CMD_INSERT;
				ctl.touch = cmd_q == CMD_ACCESS;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= ST_OK;
			vvalid_q <= 1'b0;
			cmd_q <= CMD_INSERT;
			rot_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					busy_q <= 1'b1;
					cmd_q <= cmd_t'(cmd_in);
					status_q <= ST_OK;
					vvalid_q <= 1'b0;
					if (stat.empty) begin
						if (cmd_in == CMD_INSERT) state_q <= S_AFTER;
						else begin
							status_q <= ST_EMPTY;
							state_q <= S_AFTER;
						end
					end else if (cmd_in == CMD_EVICT) state_q <= S_CHOOSE;
					else state_q <= S_SCAN;
				end
				S_SCAN: if (stat.scan_last) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (cmd_q == CMD_INSERT) begin
						if (stat.found) begin
							status_q <= ST_RESIDENT;
							state_q <= S_AFTER;
						end else if (stat.full) state_q <= S_CHOOSE;
						else state_q <= S_AFTER;
					end else if (!stat.found) begin
						status_q <= ST_NOT_FOUND;
						state_q <= S_AFTER;
					end else if (cmd_q == CMD_REMOVE) state_q <= S_CAP;
					else state_q <= S_AFTER;
				end
				S_CHOOSE: begin
					vvalid_q <= 1'b1;
					rot_q <= RW'(RESIDENT_PAGES);
					unique case (policy)
						POL_NEWEST: state_q <= S_CAP;
						POL_LEAST: state_q <= S_MINSCAN;
						default: state_q <= S_SC;
					endcase
				end
				S_SC: begin
					if (stat.head_ref && rot_q != '0) rot_q <= rot_q - RW'(1);
					else state_q <= S_CAP;
				end
				S_MINSCAN: if (stat.scan_last) state_q <= S_PICK;
				S_PICK: state_q <= S_CAP;
				S_CAP: state_q <= S_SHIFT;
				S_SHIFT: if (stat.shift_last) state_q <= S_AFTER;
				S_AFTER: begin
					if (status_q == ST_RESIDENT || status_q == ST_NOT_FOUND
						|| status_q == ST_EMPTY) begin
						// append/touch gated by status in the top level
					end
					done_q <= 1'b1;
					busy_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/page_replacement_selector.sv @@
// page replacement selector: sequencer plus entry-list datapath; depends on prs_pkg
// worst case is an insert into a full list: a scan of every entry, a second-chance pass that
// rotates every entry then picks the head, then a shift down to the tail
// throughput: one item at a time, next accepted once the result transaction is taken
// reset: asynchronous active-low; list empty, policy second-chance, no result pending
`include "page_replacement_selector_defines.svh"
module page_replacement_selector import prs_pkg::*; #(
	parameter int RESIDENT_PAGES = RESIDENT_PAGES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_data,       // policy
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,       // cmd[1:0], page_number[21:2], mark_referenced[22]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata        // status[1:0], victim_valid[2], victim_page[22:3],
	                                   // resident_count[27:23]
);
	localparam int LW = $clog2(RESIDENT_PAGES+1);
	logic [1:0] policy_q;
	prs_cmd_t ctl, ctl_g;
	prs_stat_t stat;
	logic busy, done, vvalid;
	logic [1:0] status;
	logic [PAGE_BITS-1:0] victim, page_in;
	logic [LW-1:0] live;
	logic in_fire;
	logic [31:0] out_q;
	logic [31:0] res_d;
	logic pend_q;
	logic fin_q;

	assign cfg_ready = 1'b1;
	// accept while idle and no result is being formed or waiting in the output register
	assign s_tready = !busy && !done && !fin_q && !pend_q;
	assign in_fire = s_tvalid && s_tready;
	// page field masked or zero extended to PAGE_BITS
	always_comb begin
		page_in = '0;
		for (int i = 0; i < PAGE_BITS && i < 20; i++) page_in[i] = s_tdata[2+i];
	end

	// append/touch only on a successful item
	always_comb begin
		ctl_g = ctl;
		ctl_g.append = ctl.append && status == ST_OK;
		ctl_g.touch = ctl.touch && status == ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) policy_q <= POL_SECOND;
		else if (cfg_valid) policy_q <= cfg_data;
	end

	prs_ctrl #(.RESIDENT_PAGES(RESIDENT_PAGES)) u_ctrl (
		.clk, .arst_n, .in_fire, .cmd_in(s_tdata[1:0]), .policy(policy_q), .stat,
		.ctl, .busy_q(busy), .done_q(done), .status_q(status), .vvalid_q(vvalid)
	);

	prs_datapath #(.RESIDENT_PAGES(RESIDENT_PAGES), .PAGE_BITS(PAGE_BITS),
		.COUNT_BITS(COUNT_BITS)) u_dp (
		.clk, .arst_n, .ctl(ctl_g), .stat, .page_in, .mark_in(s_tdata[22]),
		.victim_q(victim), .live_q(live)
	);

	// packed result, victim page zero when no page was evicted
	always_comb begin
		res_d = '0;
		res_d[1:0] = status;
		res_d[2] = vvalid;
		for (int i = 0; i < PAGE_OUT_BITS && i < PAGE_BITS; i++)
			res_d[3+i] = vvalid & victim[i];
		res_d[27:23] = CNT_OUT_BITS'(live);
	end

	// result register, loaded via the fin_q register after the sequencer's done so count is final
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			fin_q <= 1'b0;
			out_q <= '0;
		end else begin
			fin_q <= done;
			if (fin_q) begin
				pend_q <= 1'b1;
				out_q <= res_d;
			end else if (m_tvalid && m_tready) pend_q <= 1'b0;
		end
	end
	assign m_tvalid = pend_q;
	assign m_tdata = out_q;

	`PRS_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, busy, !s_tready)
	`PRS_ASSERT_IMPL(a_live_bound, clk, arst_n, 1'b1, live <= LW'(RESIDENT_PAGES))
	`PRS_ASSERT_NEXT(a_fin_pend, clk, arst_n, fin_q, m_tvalid)
endmodule
